@@ sv/bms_pkg.sv @@
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants for the radix-2 Booth signed multiplier.
// ----------------------------------------------------------------------------
package bms_pkg;

    // Operand and result field widths
    localparam int IN_W      = 32;
    localparam int OUT_W     = 64;
    localparam int CFG_W     = 6;

    // Supported operand width range
    localparam int MAX_WIDTH_DEF = 32;
    localparam int MIN_WIDTH     = 2;

    // Operand width register reset value
    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd32;

    // Booth recoding of {q[0], q-1}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

@@ sv/bms_cell.sv @@
// ----------------------------------------------------------------------------
// bms_cell
// One Booth step: add/subtract the multiplicand, then arithmetic right shift
// of {A, Q, Q-1}. Holds its result in a register with its own valid bit.
// ----------------------------------------------------------------------------
module bms_cell
    import bms_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // upstream side
    input  logic                 valid_in,
    output logic                 ready_out,
    input  logic [MAX_WIDTH:0]   a_in,
    input  logic [MAX_WIDTH-1:0] q_in,
    input  logic                 q1_in,
    input  logic [MAX_WIDTH:0]   m_in,
    // downstream side
    output logic                 valid_out,
    input  logic                 ready_in,
    output logic [MAX_WIDTH:0]   a_out,
    output logic [MAX_WIDTH-1:0] q_out,
    output logic                 q1_out,
    output logic [MAX_WIDTH:0]   m_out
);

    logic                 valid_reg;
    logic [MAX_WIDTH:0]   a_reg;
    logic [MAX_WIDTH:0]   a_next;
    logic [MAX_WIDTH-1:0] q_reg;
    logic [MAX_WIDTH-1:0] q_next;
    logic                 q1_reg;
    logic [MAX_WIDTH:0]   m_reg;
    logic [MAX_WIDTH:0]   sum;

    // Cell takes a new transfer when empty or when its content moves on
    assign ready_out = !valid_reg || ready_in;

    // Booth add/subtract, then combined arithmetic shift
    always_comb
    begin
        case ({q_in[0], q1_in})
            BOOTH_ADD: sum = a_in + m_in;
            BOOTH_SUB: sum = a_in - m_in;
            default:   sum = a_in;
        endcase
        a_next = {sum[MAX_WIDTH], sum[MAX_WIDTH:1]};
        q_next = {sum[0], q_in[MAX_WIDTH-1:1]};
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            a_reg  <= a_next;
            q_reg  <= q_next;
            q1_reg <= q_in[0];
            m_reg  <= m_in;
        end
    end

    assign valid_out = valid_reg;
    assign a_out     = a_reg;
    assign q_out     = q_reg;
    assign q1_out    = q1_reg;
    assign m_out     = m_reg;

endmodule

@@ sv/booth_signed_multiplier.sv @@
// Flow: each input transfer passes through the chain of Booth step cells, one
// registered cell per Booth step, before its product is valid.
// Throughput: one operand pair per cycle; each cell holds one item and the
// chain advances whenever the output side is not stalled.
// Reset: asynchronous, active low; clears all cell valid bits and sets
// the operand width register to 32.
// ----------------------------------------------------------------------------
// booth_signed_multiplier
// Pipelined radix-2 Booth signed multiplier built from a chain of step cells.
// ----------------------------------------------------------------------------
module booth_signed_multiplier
    import bms_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  multiplicand,
    input  logic signed [IN_W-1:0]  multiplier,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] product
);

    localparam int IDX_W = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     eff_width;
    logic [CFG_W-1:0]     eff_m1;
    logic [MAX_WIDTH-1:0] mcand_ext;
    logic [MAX_WIDTH-1:0] mplier_ext;

    // Chain links, index k feeds cell k
    logic                 valid_chain [0:MAX_WIDTH];
    logic                 ready_chain [0:MAX_WIDTH];
    logic [MAX_WIDTH:0]   a_chain     [0:MAX_WIDTH];
    logic [MAX_WIDTH-1:0] q_chain     [0:MAX_WIDTH];
    logic                 q1_chain    [0:MAX_WIDTH];
    logic [MAX_WIDTH:0]   m_chain     [0:MAX_WIDTH];

    // Operand width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            width_reg <= cfg_wr_data;
        end
    end

    // Clamp width to the supported range
    always_comb
    begin
        if (width_reg < CFG_W'(MIN_WIDTH))
        begin
            eff_width = CFG_W'(MIN_WIDTH);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            eff_width = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
        eff_m1 = eff_width - 1'b1;
    end

    // Truncate operands to the effective width and sign-extend to MAX_WIDTH
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            if (CFG_W'(i) < eff_width)
            begin
                mcand_ext[i]  = multiplicand[i];
                mplier_ext[i] = multiplier[i];
            end
            else
            begin
                mcand_ext[i]  = multiplicand[eff_m1[IDX_W-1:0]];
                mplier_ext[i] = multiplier[eff_m1[IDX_W-1:0]];
            end
        end
    end

    // Head of chain: A = 0, Q = multiplier, Q-1 = 0
    assign valid_chain[0] = in_valid;
    assign a_chain[0]     = '0;
    assign q_chain[0]     = mplier_ext;
    assign q1_chain[0]    = 1'b0;
    assign m_chain[0]     = {mcand_ext[MAX_WIDTH-1], mcand_ext};
    assign in_stall       = !ready_chain[0];

    // One cell per Booth step
    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_cell
        bms_cell #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[k]),
            .ready_out (ready_chain[k]),
            .a_in      (a_chain[k]),
            .q_in      (q_chain[k]),
            .q1_in     (q1_chain[k]),
            .m_in      (m_chain[k]),
            .valid_out (valid_chain[k+1]),
            .ready_in  (ready_chain[k+1]),
            .a_out     (a_chain[k+1]),
            .q_out     (q_chain[k+1]),
            .q1_out    (q1_chain[k+1]),
            .m_out     (m_chain[k+1])
        );
    end

    // Tail of chain drives the output channel
    assign ready_chain[MAX_WIDTH] = !out_stall;
    assign out_valid = valid_chain[MAX_WIDTH];
    assign product   = OUT_W'(signed'({a_chain[MAX_WIDTH][MAX_WIDTH-1:0],
                                       q_chain[MAX_WIDTH]}));

`ifndef SYNTHESIS
    // An unstalled output lets the whole chain advance
    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output side is free");

    // Effective width stays within the supported range
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (eff_width >= CFG_W'(MIN_WIDTH)) && (eff_width <= CFG_W'(MAX_WIDTH)))
        else $error("effective operand width out of range");

    // Top multiplier bit carries the sign of the truncated operand
    a_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (mplier_ext[MAX_WIDTH-1] == multiplier[eff_m1[IDX_W-1:0]]))
        else $error("multiplier sign extension mismatch");
`endif

endmodule

@@ tb/booth_product_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// booth_product_checker
// Watches the operand and product channels of the Booth multiplier, tracks
// the operand width register, predicts each signed product and compares it
// with the product that comes out, in order.
// ----------------------------------------------------------------------------
module booth_product_checker
    import bms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [IN_W-1:0]  multiplicand,
    input  logic signed [IN_W-1:0]  multiplier,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] product,
    output int                      fail_count,
    output int                      checked_count,
    output logic                    drained
);

    localparam int REPORT_LIMIT = 10;

    // One outstanding product, with its operands kept for the report
    typedef struct {
        logic [IN_W-1:0]         a;
        logic [IN_W-1:0]         b;
        logic [CFG_W-1:0]        width;
        logic signed [OUT_W-1:0] value;
    } pending_product_t;

    pending_product_t  product_fifo[$];
    pending_product_t  head;
    logic [CFG_W-1:0]  width_copy;
    int                err_total;
    int                checked_total;

    // Signed product of both operands cut to the clamped width
    function automatic logic signed [OUT_W-1:0] booth_product(
        input logic [IN_W-1:0]  a,
        input logic [IN_W-1:0]  b,
        input logic [CFG_W-1:0] w
    );
        int                      n;
        logic signed [OUT_W-1:0] sa;
        logic signed [OUT_W-1:0] sb;
        n = (w < MIN_WIDTH) ? MIN_WIDTH : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w));
        sa = {32'b0, a};
        sb = {32'b0, b};
        // sign-extend from bit n-1
        sa = (sa <<< (OUT_W - n)) >>> (OUT_W - n);
        sb = (sb <<< (OUT_W - n)) >>> (OUT_W - n);
        return sa * sb;
    endfunction

    // Track config, queue expected products, compare finished ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_copy <= WIDTH_RESET;
            product_fifo.delete();
            err_total = 0;
            checked_total = 0;
            fail_count <= 0;
            checked_count <= 0;
            drained <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
                width_copy <= cfg_wr_data;

            // product transfer: check before queuing this edge's operands
            if (out_valid && !out_stall)
            begin
                if (product_fifo.size() == 0)
                begin
                    err_total++;
                    if (err_total <= REPORT_LIMIT)
                        $display("unexpected product %0d with nothing pending", product);
                end
                else
                begin
                    head = product_fifo.pop_front();
                    checked_total++;
                    if (product !== head.value)
                    begin
                        err_total++;
                        if (err_total <= REPORT_LIMIT)
                            $display("mismatch: %0d x %0d width %0d: expected %0d, got %0d",
                                     $signed(head.a), $signed(head.b), head.width,
                                     head.value, product);
                    end
                end
            end

            // operand transfer
            if (in_valid && !in_stall)
            begin
                head.a = multiplicand;
                head.b = multiplier;
                head.width = width_copy;
                head.value = booth_product(multiplicand, multiplier, width_copy);
                product_fifo.push_back(head);
            end

            fail_count <= err_total;
            checked_count <= checked_total;
            drained <= (product_fifo.size() == 0);
        end
    end

endmodule

@@ tb/tb_booth_signed_multiplier.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_booth_signed_multiplier
// Drives operand pairs into the Booth multiplier under several operand
// widths, including out-of-range ones, with random idle and stall cycles, a
// long output hold-off and a calm stretch; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_booth_signed_multiplier;
    import bms_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1200;
    localparam int DRAIN_CYCLES = 2 * MAX_WIDTH_DEF + 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [IN_W-1:0]  multiplicand = '0;
    logic signed [IN_W-1:0]  multiplier = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] product;

    int   fail_count;
    int   checked_count;
    logic drained;

    int   cycle_count = 0;
    int   sent_count = 0;
    int   width_settings = 0;
    logic calm_window = 1'b0;
    logic hold_req = 1'b0;

    booth_signed_multiplier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .product      (product)
    );

    booth_product_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .multiplicand  (multiplicand),
        .multiplier    (multiplier),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .product       (product),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .drained       (drained)
    );

    // 4 ns clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one operand pair and wait for its transfer
    task automatic offer_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        if (!calm_window && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        multiplicand <= a;
        multiplier <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        calm_window <= (sent_count >= CALM_FROM && sent_count < CALM_TO);
        if (sent_count == HOLD_AT)
            hold_req <= 1'b1;
    endtask

    // Stop offering and wait until every product is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (!drained)
            @(posedge clk);
    endtask

    // Width register write, only with the pipeline empty
    task automatic write_width(input logic [CFG_W-1:0] w);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_settings++;
    endtask

    // Operand with a corner pattern or random bits in the low n bits;
    // bits above n are always random to exercise truncation
    function automatic logic [IN_W-1:0] pick_operand(input int n);
        logic [IN_W-1:0] mask;
        logic [IN_W-1:0] noise;
        logic [IN_W-1:0] low_min;
        logic [IN_W-1:0] pat;
        mask = (n >= IN_W) ? '1 : ((32'h1 << n) - 1);
        low_min = 32'h1 << (n - 1);
        noise = $urandom;
        case ($urandom_range(0, 9))
            0: pat = low_min;
            1: pat = low_min - 1;
            2: pat = '1;
            3: pat = '0;
            4: pat = 32'h1;
            default: pat = $urandom;
        endcase
        return (noise & ~mask) | (pat & mask);
    endfunction

    // Receiver: random stalls, one long hold-off, none in the calm stretch
    initial
    begin
        int   hold_left;
        logic held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (calm_window)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int p;
        int w;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner operands at the reset width
        offer_pair(32'h8000_0000, 32'h8000_0000);
        offer_pair(32'h8000_0000, 32'h7FFF_FFFF);
        offer_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_pair(32'h8000_0000, 32'hFFFF_FFFF);
        offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_pair(32'h0000_0001, 32'hFFFF_FFFF);
        offer_pair(32'h0000_0000, 32'h8000_0000);
        offer_pair(32'h0000_0000, 32'h0000_0000);
        offer_pair(32'hAAAA_AAAA, 32'h5555_5555);
        offer_pair(32'h7FFF_FFFF, 32'h8000_0001);

        // width below the minimum acts as 2
        write_width(6'd0);
        offer_pair(32'hFFFF_FFFE, 32'h0000_0003);
        offer_pair(32'h1234_5671, 32'hFFFF_FFFE);
        write_width(6'd1);
        offer_pair(32'h0000_0002, 32'h0000_0002);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0001);

        // width above the maximum acts as 32
        write_width(6'd63);
        offer_pair(32'h8000_0000, 32'h8000_0000);
        offer_pair(32'h7FFF_FFFF, 32'h8000_0000);

        // narrowest real width
        write_width(MIN_WIDTH[CFG_W-1:0]);
        offer_pair(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        offer_pair(32'h0000_0001, 32'hFFFF_FFFE);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0001);

        // random phases, one width setting each
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: w = 2;
                1: w = 32;
                2: w = 63;
                3: w = 0;
                4: w = 1;
                5: w = 16;
                6: w = 33;
                7: w = 7;
                default: w = $urandom_range(0, 63);
            endcase
            write_width(w[CFG_W-1:0]);
            n = (w < MIN_WIDTH) ? MIN_WIDTH : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
            repeat (PHASE_ITEMS)
                offer_pair(pick_operand(n), pick_operand(n));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operand pairs under %0d width settings, %0d products checked.",
                 sent_count, width_settings, checked_count);
        $display("Widths covered the clamped low and high ends, 2, 32 and random values.");
        if (fail_count == 0 && drained)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
sv/bms_pkg.sv
sv/bms_cell.sv
sv/booth_signed_multiplier.sv
tb/booth_product_checker.sv
tb/tb_booth_signed_multiplier.sv
